// File: rtl/mat4mul_pkg.sv
// mat4mul_pkg: shared types and constants for the matrix multiply block.
// No dependencies.
`default_nettype none

package mat4mul_pkg;

  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned MAX_ROW_W  = 3;

  localparam logic [KIND_W-1:0] KIND_WR_CUR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_OPR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MULTIPLY = 2'd2;

  localparam logic [ELEM_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [MAX_ROW_W-1:0] row;
    logic [MAX_ROW_W-1:0] col;
    logic [INDEX_W-1:0]   idx;
    logic                 last;
  } elem_tag_t;

  typedef struct packed {
    logic              wr_cur;
    logic              wr_opr;
    logic              issue;
    logic              sel;
    logic [ELEM_W-1:0] value;
    elem_tag_t         tag;
  } dp_cmd_t;

  typedef struct packed {
    logic adv;
    logic busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/mat4mul_if.sv
// mat4mul_req_if / mat4mul_rsp_if: valid/ready channels of the matrix multiply block.
// Depends on mat4mul_pkg.
`default_nettype none

interface mat4mul_req_if;
  import mat4mul_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [INDEX_W-1:0]  element_index;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, kind, element_index, element_value, input ready);
  modport sink   (input valid, kind, element_index, element_value, output ready);
endinterface

interface mat4mul_rsp_if;
  import mat4mul_pkg::*;
  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  result_index;
  logic signed [ELEM_W-1:0] result_value;
  logic                saturated;
  logic                last;

  modport source (output valid, result_index, result_value, saturated, last, input ready);
  modport sink   (input valid, result_index, result_value, saturated, last, output ready);
endinterface

`default_nettype wire

// File: rtl/mat4mul_ctrl.sv
// mat4mul_ctrl: item decode and multiply sequencer (row/column counters, bank select).
// Depends on mat4mul_pkg and mat4mul_req_if.
`default_nettype none

module mat4mul_ctrl
  import mat4mul_pkg::*;
#(
  parameter int unsigned DIM = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  mat4mul_req_if.sink     req,
  output dp_cmd_t         cmd,
  input  dp_stat_t        stat
);

  localparam int unsigned ROW_W = $clog2(DIM);
  localparam int unsigned NELEM = DIM * DIM;
  localparam int unsigned K_W   = $clog2(NELEM);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state;
  logic [ROW_W-1:0] row_cnt;
  logic [ROW_W-1:0] col_cnt;
  logic [K_W-1:0]   k;
  logic             sel;

  logic [ROW_W-1:0] row_tab [16];
  logic [ROW_W-1:0] col_tab [16];
  logic             acc;
  logic             idx_ok;
  logic             last_elem;

  for (genvar g = 0; g < 16; g++) begin : g_tab
    assign row_tab[g] = ROW_W'(g / DIM);
    assign col_tab[g] = ROW_W'(g % DIM);
  end

  assign req.ready = (state == ST_IDLE);
  assign acc       = req.valid && req.ready;
  assign idx_ok    = ({3'b000, req.element_index} < 7'(NELEM));
  assign last_elem = (k == K_W'(NELEM - 1));

  always_comb begin
    cmd.wr_cur   = acc && (req.kind == KIND_WR_CUR) && idx_ok;
    cmd.wr_opr   = acc && (req.kind == KIND_WR_OPR) && idx_ok;
    cmd.issue    = (state == ST_RUN) && stat.adv;
    cmd.sel      = sel;
    cmd.value    = req.element_value;
    cmd.tag.idx  = INDEX_W'(k);
    cmd.tag.last = last_elem;
    if (state == ST_IDLE) begin
      cmd.tag.row = MAX_ROW_W'(row_tab[req.element_index]);
      cmd.tag.col = MAX_ROW_W'(col_tab[req.element_index]);
    end else begin
      cmd.tag.row = MAX_ROW_W'(row_cnt);
      cmd.tag.col = MAX_ROW_W'(col_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      row_cnt <= '0;
      col_cnt <= '0;
      k       <= '0;
      sel     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          row_cnt <= '0;
          col_cnt <= '0;
          k       <= '0;
          if (acc && (req.kind == KIND_MULTIPLY)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (stat.adv) begin
            k <= k + K_W'(1);
            if (col_cnt == ROW_W'(DIM - 1)) begin
              col_cnt <= '0;
              row_cnt <= row_cnt + ROW_W'(1);
            end else begin
              col_cnt <= col_cnt + ROW_W'(1);
            end
            if (last_elem) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!stat.busy) begin
            sel   <= ~sel;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/mat4mul_dp.sv
// mat4mul_dp: lane memories, DIM multipliers, adder stages, shift/saturate and
// output register. Depends on mat4mul_pkg and mat4mul_rsp_if.
`default_nettype none

module mat4mul_dp
  import mat4mul_pkg::*;
#(
  parameter int unsigned DIM       = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat,
  mat4mul_rsp_if.source   rsp
);

  localparam int unsigned ROW_W  = $clog2(DIM);
  localparam int unsigned HALF   = DIM / 2;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned SUM_W  = PROD_W + $clog2(DIM) + 1;

  logic adv;

  logic                     v1, v2, v3, v4;
  elem_tag_t                t1, t2, t3, t4;
  logic signed [ELEM_W-1:0] cur_q [DIM];
  logic signed [ELEM_W-1:0] opr_q [DIM];
  logic signed [PROD_W-1:0] prod  [DIM];
  logic signed [SUM_W-1:0]  sum_lo, sum_hi, total;
  logic signed [SUM_W-1:0]  sum_lo_next, sum_hi_next;

  logic signed [SUM_W-1:0]  shifted;
  logic                     fits;
  logic [ELEM_W-1:0]        sat_val;
  logic                     sat_flag;
  logic                     wb;

  logic                     out_valid;
  logic [INDEX_W-1:0]       out_index;
  logic [ELEM_W-1:0]        out_value;
  logic                     out_sat;
  logic                     out_last;

  assign adv       = !out_valid || rsp.ready;
  assign stat.adv  = adv;
  assign stat.busy = v1 || v2 || v3 || v4;
  assign wb        = adv && v4;

  // shift and saturate
  assign shifted  = total >>> FRAC_BITS;
  assign fits     = (shifted[SUM_W-1:ELEM_W-1] == '0) || (shifted[SUM_W-1:ELEM_W-1] == '1);
  assign sat_flag = !fits;
  assign sat_val  = fits ? shifted[ELEM_W-1:0] : (total[SUM_W-1] ? Q_MIN : Q_MAX);

  // lane e: column e of current (two halves, select by bank), row e of operand
  for (genvar e = 0; e < DIM; e++) begin : g_lane
    logic [ELEM_W-1:0] cur_mem [2 << ROW_W];
    logic [ELEM_W-1:0] opr_mem [DIM];
    logic              cur_we;
    logic [ROW_W:0]    cur_waddr;
    logic [ELEM_W-1:0] cur_wdata;

    always_comb begin
      cur_we    = (cmd.wr_cur && (cmd.tag.col[ROW_W-1:0] == ROW_W'(e)))
                  || (wb && (t4.col[ROW_W-1:0] == ROW_W'(e)));
      cur_waddr = wb ? {~cmd.sel, t4.row[ROW_W-1:0]} : {cmd.sel, cmd.tag.row[ROW_W-1:0]};
      cur_wdata = wb ? sat_val : cmd.value;
    end

    always_ff @(posedge clk) begin
      if (cur_we) begin
        cur_mem[cur_waddr] <= cur_wdata;
      end
      if (adv) begin
        cur_q[e] <= cur_mem[{cmd.sel, cmd.tag.row[ROW_W-1:0]}];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.wr_opr && (cmd.tag.row[ROW_W-1:0] == ROW_W'(e))) begin
        opr_mem[cmd.tag.col[ROW_W-1:0]] <= cmd.value;
      end
      if (adv) begin
        opr_q[e] <= opr_mem[cmd.tag.col[ROW_W-1:0]];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        prod[e] <= cur_q[e] * opr_q[e];
      end
    end
  end

  always_comb begin
    sum_lo_next = '0;
    sum_hi_next = '0;
    for (int i = 0; i < DIM; i++) begin
      if (i < HALF) begin
        sum_lo_next = sum_lo_next + SUM_W'(prod[i]);
      end else begin
        sum_hi_next = sum_hi_next + SUM_W'(prod[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1     <= cmd.tag;
      t2     <= t1;
      t3     <= t2;
      t4     <= t3;
      sum_lo <= sum_lo_next;
      sum_hi <= sum_hi_next;
      total  <= sum_lo + sum_hi;
    end
    if (wb) begin
      out_index <= t4.idx;
      out_value <= sat_val;
      out_sat   <= sat_flag;
      out_last  <= t4.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= cmd.issue;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_index = out_index;
  assign rsp.result_value = out_value;
  assign rsp.saturated    = out_sat;
  assign rsp.last         = out_last;

endmodule

`default_nettype wire

// File: rtl/matrix4_multiply.sv
// matrix4_multiply: top level of the fixed-point square matrix multiplier.
// Depends on mat4mul_pkg, mat4mul_if, mat4mul_ctrl and mat4mul_dp.
//
// An element write is accepted whenever the block is idle. A multiply issues one product element
// per cycle while rsp does not stall, DIM*DIM elements in all (16 for DIM = 4), through DIM lane
// multipliers fed by per-lane current and operand memories; the five-stage
// pipeline (read, multiply, two adds, shift/saturate into the output
// register) then drains before the next item is taken. Backpressure on
// rsp stalls the whole pipeline. Results of a multiply are written into the
// spare bank of the current matrix and the banks swap once it completes.
`default_nettype none

module matrix4_multiply
  import mat4mul_pkg::*;
#(
  parameter int unsigned DIM       = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  mat4mul_req_if.sink     req,
  mat4mul_rsp_if.source   rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mat4mul_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat)
  );

  mat4mul_dp #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for matrix4_multiply. Loads both matrices, runs chained
// multiplies under random source bursts and sink stalls. Depends on mat4mul_pkg, mat4mul_if, RTL.

module tb;
  import mat4mul_pkg::*;

  localparam int unsigned N            = 4;
  localparam int unsigned FRAC         = 16;
  localparam int unsigned NUM_ELEM     = N * N;
  localparam int unsigned RANDOM_ITEMS = 340;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [65:0] SUM_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SUM_MIN = -66'sd2147483648;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [ELEM_W-1:0]  value;
    logic               sat;
    logic               last;
  } product_elem_t;

  typedef enum {RX_FREE, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_e;

  class mat_product_tracker;
    logic [ELEM_W-1:0] cur_m [NUM_ELEM];
    logic [ELEM_W-1:0] opr_m [NUM_ELEM];
    product_elem_t     pending_q [$];
    int unsigned       mismatches = 0;

    function void note_request(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                               logic [ELEM_W-1:0] val);
      logic [ELEM_W-1:0]  next_m [NUM_ELEM];
      logic signed [65:0] acc;
      logic signed [63:0] prod;
      product_elem_t      e;
      case (kind)
        KIND_WR_CUR: cur_m[idx] = val;
        KIND_WR_OPR: opr_m[idx] = val;
        KIND_MULTIPLY: begin
          for (int r = 0; r < N; r++) begin
            for (int c = 0; c < N; c++) begin
              acc = '0;
              for (int k = 0; k < N; k++) begin
                prod = $signed(cur_m[r*N+k]) * $signed(opr_m[k*N+c]);
                acc = acc + prod;
              end
              acc = acc >>> FRAC;
              e.idx = INDEX_W'(r*N + c);
              e.sat = (acc > SUM_MAX) || (acc < SUM_MIN);
              if (acc > SUM_MAX) e.value = Q_MAX;
              else if (acc < SUM_MIN) e.value = Q_MIN;
              else e.value = acc[ELEM_W-1:0];
              e.last = (r == N-1) && (c == N-1);
              next_m[r*N+c] = e.value;
              pending_q.push_back(e);
            end
          end
          cur_m = next_m;
        end
        default: ;
      endcase
    endfunction

    function void check_element(product_elem_t got);
      product_elem_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected item: result_index %0d result_value %h", got.idx, got.value);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      if (got.idx !== want.idx) begin
        $error("result_index: expected %0d, actual %0d", want.idx, got.idx);
        mismatches++;
      end
      if (got.value !== want.value) begin
        $error("result_value: expected %h, actual %h", want.value, got.value);
        mismatches++;
      end
      if (got.sat !== want.sat) begin
        $error("saturated: expected %b, actual %b", want.sat, got.sat);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  mat4mul_req_if req_ch();
  mat4mul_rsp_if rsp_ch();

  matrix4_multiply #(.DIM(N), .FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  mat_product_tracker tracker;
  int unsigned        burst_left   = 0;
  int unsigned        idle_cycles  = 0;
  rx_mode_e           rx_mode      = RX_FREE;
  int unsigned        rx_mode_left = 0;
  int unsigned        rx_tick      = 0;
  int unsigned        rx_hold      = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [ELEM_W-1:0] pick_value(bit tame);
    logic [ELEM_W-1:0] v;
    if (tame) begin
      v = $urandom_range(0, 32'h0001_8000);
      if ($urandom_range(0, 1)) v = -v;
      return v;
    end
    case ($urandom_range(0, 9))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2: v = '0;
      3: v = '1;
      4, 5, 6: v = $urandom();
      default: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                           logic [ELEM_W-1:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        req_ch.valid <= 1'b0;
        @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= kind;
    req_ch.element_index <= idx;
    req_ch.element_value <= val;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    tracker.note_request(kind, idx, val);
    @(negedge clk);
  endtask

  task automatic run_directed();
    logic [ELEM_W-1:0] seed_vals [NUM_ELEM];
    seed_vals = '{Q_MAX, Q_MIN, 32'h0, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'hFFFF_0000, 32'h1, 32'h0000_8000,
                  32'h0002_8000, 32'hFFFD_8000, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h0000_FFFF, 32'h7FFF_0000, 32'h8000_FFFF, 32'h0003_0000};
    for (int i = 0; i < NUM_ELEM; i++)
      send_item(KIND_WR_CUR, INDEX_W'(i), seed_vals[i]);
    for (int i = 0; i < NUM_ELEM; i++)
      send_item(KIND_WR_OPR, INDEX_W'(i), (i % (N+1) == 0) ? 32'h0001_0000 : 32'h0);
    // identity operand: product echoes current
    send_item(KIND_MULTIPLY, 4'hF, Q_MAX);
    send_item(KIND_UNUSED, 4'h0, 32'hDEAD_BEEF);
    // clip high and low in row 0, floor of negative fractions in column 2
    send_item(KIND_WR_OPR, 4'd0, Q_MAX);
    send_item(KIND_WR_OPR, 4'd5, Q_MAX);
    send_item(KIND_WR_OPR, 4'd10, 32'hFFFF_FFFF);
    send_item(KIND_MULTIPLY, 4'h0, 32'h0);
    send_item(KIND_MULTIPLY, 4'h5, 32'hFFFF_FFFF);
  endtask

  task automatic run_random();
    int unsigned counted;
    int unsigned n_wr;
    bit          tame_run;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        tame_run = $urandom_range(0, 2) != 0;
        for (int i = 0; i < NUM_ELEM; i++)
          send_item(KIND_WR_CUR, INDEX_W'(i), pick_value(tame_run));
        counted += NUM_ELEM;
      end
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < NUM_ELEM; i++)
          send_item(KIND_WR_OPR, INDEX_W'(i), pick_value(1'b1));
        counted += NUM_ELEM;
      end
      if ($urandom_range(0, 9) == 0)
        send_item(KIND_UNUSED, INDEX_W'($urandom()), $urandom());
      n_wr = $urandom_range(0, 5);
      repeat (n_wr) begin
        send_item($urandom_range(0, 1) ? KIND_WR_OPR : KIND_WR_CUR, INDEX_W'($urandom()),
                  pick_value($urandom_range(0, 2) != 0));
        counted++;
      end
      send_item(KIND_MULTIPLY, INDEX_W'($urandom()), $urandom());
      counted++;
    end
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_WR_CUR;
    req_ch.element_index = '0;
    req_ch.element_value = '0;
    rsp_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    req_ch.valid <= 1'b0;
    while (tracker.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // sink stall pattern from a randomly picked mode (free, coin, periodic, bursty)
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 150);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_FREE: rsp_ch.ready <= 1'b1;
      RX_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: begin
        rx_tick++;
        rsp_ch.ready <= (rx_tick % 4) != 0;
      end
      RX_BURSTY: begin
        if (rx_hold != 0) begin
          rx_hold--;
          rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_hold = $urandom_range(2, 10);
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
      default: rsp_ch.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      tracker.check_element(product_elem_t'{rsp_ch.result_index, rsp_ch.result_value,
                                            rsp_ch.saturated, rsp_ch.last});
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
